// File: src/metaball_dither_pixel_shader_core_macros.svh
// Assertion macros for the metaball dither shader core.
// Used by the top level only; compiled to nothing under SYNTHESIS.
`ifndef METABALL_DITHER_PIXEL_SHADER_CORE_MACROS_SVH
`define METABALL_DITHER_PIXEL_SHADER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MDPS_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mdps check failed");
`define MDPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mdps check failed");
`else
`define MDPS_ASSERT_IMPLY(label, ante, cons)
`define MDPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/mdps_pkg.sv
// Shared types, constants and functions of the metaball dither shader core.
// No dependencies.
package mdps_pkg;

  localparam int SCREEN_WIDTH  = 256;
  localparam int SCREEN_HEIGHT = 256;
  localparam int BLOB_COUNT    = 5;
  localparam int EDGE_MARGIN   = 5;
  localparam int BLOB_IDX_W    = 3;

  localparam int FIELD_W = 28;  // sum of contributions, Q.8
  localparam int QUOT_W  = 25;  // one contribution
  localparam int DEN_W   = 34;  // d2 + 1.0 in Q18.16
  localparam int ROOT_W  = 18;

  localparam logic [16:0] EDGE_LO = 17'(EDGE_MARGIN * 256);
  localparam logic [16:0] EDGE_HI_X =
    17'(((SCREEN_WIDTH - EDGE_MARGIN) * 256 > 65535) ? 65535
        : (SCREEN_WIDTH - EDGE_MARGIN) * 256);
  localparam logic [16:0] EDGE_HI_Y =
    17'(((SCREEN_HEIGHT - EDGE_MARGIN) * 256 > 65535) ? 65535
        : (SCREEN_HEIGHT - EDGE_MARGIN) * 256);

  localparam logic [1:0] CFG_PALETTE  = 2'd0;
  localparam logic [1:0] CFG_STRENGTH = 2'd1;
  localparam logic [1:0] CFG_GAIN     = 2'd2;
  localparam logic [1:0] CFG_PHASE    = 2'd3;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_SHADE = 2'd2;

  // 4x4 Bayer matrix, row-major: index {y[1:0], x[1:0]}
  localparam logic [3:0] BAYER [16] = '{
    4'd0,  4'd8,  4'd2,  4'd10,
    4'd12, 4'd4,  4'd14, 4'd6,
    4'd3,  4'd11, 4'd1,  4'd9,
    4'd15, 4'd7,  4'd13, 4'd5
  };

  typedef enum logic [3:0] {
    ST_IDLE, ST_TICK, ST_DIST, ST_SQ, ST_DEN, ST_DIV, ST_ROOT, ST_ROOT_WAIT,
    ST_MUL, ST_OUT
  } state_t;

  typedef struct packed {
    logic [15:0]       px;
    logic [15:0]       py;
    logic signed [8:0] vx;
    logic signed [8:0] vy;
  } blob_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic [15:0]       pos;
    logic signed [8:0] vel;
  } axis_t;

  function automatic axis_t move_axis(logic [15:0] pos, logic signed [8:0] vel,
                                      logic [16:0] hi);
    logic signed [17:0] p;
    logic signed [17:0] lo_s;
    logic signed [17:0] hi_s;
    axis_t r;
    p    = $signed({2'b00, pos}) + 18'(vel);
    lo_s = $signed({1'b0, EDGE_LO});
    hi_s = $signed({1'b0, hi});
    r.vel = vel;
    if (p < lo_s || p > hi_s) begin
      r.vel = (vel == -9'sd256) ? 9'sd255 : -vel;
    end
    if (p < lo_s) p = lo_s;
    if (p > hi_s) p = hi_s;
    r.pos = p[15:0];
    return r;
  endfunction

endpackage

// File: src/mdps_blob_cell.sv
// One blob cell of the rotating blob ring: holds a position and velocity.
// Depends on mdps_pkg.
module mdps_blob_cell import mdps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  blob_t     load_data,
  input  blob_t     from_next,
  output blob_t     blob
);

  blob_t blob_r, blob_nxt;

  always_comb begin
    blob_nxt = blob_r;
    if (ctl.load) begin
      blob_nxt = load_data;
    end else if (ctl.shift) begin
      blob_nxt = from_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blob_r <= '0;
    end else begin
      blob_r <= blob_nxt;
    end
  end

  assign blob = blob_r;

endmodule

// File: src/mdps_div.sv
// Restoring divider: (strength << 24) / den, one quotient bit a cycle.
// Depends on mdps_pkg.
module mdps_div import mdps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [15:0]       strength,
  input  logic [DEN_W-1:0]  den,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [QUOT_W-1:0] q_r, q_nxt;
  logic [QUOT_W-1:0] num_r, num_nxt;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign trial = {rem_r, num_r[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    num_nxt  = num_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(QUOT_W);
      // dividend bits above the quotient width are strength[15:1]
      rem_nxt  = DEN_W'(strength[15:1]);
      num_nxt  = {strength[0], 24'd0};
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
      q_nxt    = {q_r[QUOT_W-2:0], ge};
      num_nxt  = {num_r[QUOT_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
    num_r <= num_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: src/mdps_sqrt.sv
// Integer square root of (field << 8), two radicand bits a cycle.
// Depends on mdps_pkg.
module mdps_sqrt import mdps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [FIELD_W-1:0] field,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [2*ROOT_W-1:0]   v_r, v_nxt;
  logic [ROOT_W+1:0]     rem_r, rem_nxt;
  logic [ROOT_W-1:0]     root_r, root_nxt;
  logic [ROOT_W+2:0]     rem2;
  logic [ROOT_W+1:0]     trial;
  logic                  ge;

  assign rem2  = {rem_r[ROOT_W:0], v_r[2*ROOT_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign ge    = rem2 >= {1'b0, trial};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'(ROOT_W);
      v_nxt    = {field, 8'd0};
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? (ROOT_W+2)'(rem2 - {1'b0, trial}) : rem2[ROOT_W+1:0];
      root_nxt = {root_r[ROOT_W-2:0], ge};
      v_nxt    = {v_r[2*ROOT_W-3:0], 2'b00};
      cnt_nxt  = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r    <= v_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// File: src/metaball_dither_pixel_shader_core.sv
// Metaball dither pixel shader core: top level with sequencer and blob ring.
// Depends on mdps_pkg, mdps_blob_cell, mdps_div, mdps_sqrt and the macros header.
//
// One item at a time. A load writes its blob cell as it is accepted; a frame
// tick rotates the blobs once around a ring of cells and moves each as it
// leaves the head cell. A shade item walks the ring the same way without
// moving the blobs and runs one restoring divide per blob, then a square
// root, then scales, dithers and registers the result. The result sits in an
// output register; a new item is taken as soon as the sequencer is idle.
`include "metaball_dither_pixel_shader_core_macros.svh"
module metaball_dither_pixel_shader_core import mdps_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // blob_index[2:0], blob_x[18:3], blob_y[34:19], blob_vx[43:35],
  // blob_vy[52:44], drift_enable[53], pixel_x[61:54], pixel_y[69:62]
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // colour_index[7:0], out_x[15:8], out_y[23:16]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [BLOB_IDX_W-1:0] blob_cnt_r, blob_cnt_nxt;

  logic [63:0] palette_r;
  logic [15:0] strength_r;
  logic [9:0]  gain_r;
  logic [15:0] step_r;
  logic [15:0] phase_r, phase_nxt;

  logic [7:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [16:0] dx_r, dx_nxt, dy_r, dy_nxt;
  logic [31:0] sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [DEN_W-1:0] den;
  logic [FIELD_W-1:0] acc_r, acc_nxt;
  logic [18:0] t_r, t_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_data_r, out_data_nxt;

  logic in_acc;
  logic [1:0] cmd;
  blob_t load_blob;
  logic [BLOB_IDX_W-1:0] load_idx;

  cell_ctl_t ctl [BLOB_COUNT];
  blob_t     cell_out [BLOB_COUNT];
  blob_t     cell_in  [BLOB_COUNT];
  blob_t     moved;
  axis_t     mx, my;
  logic      ring_shift;
  logic      ring_move;
  logic      load_en;

  logic              div_start, div_done;
  logic [QUOT_W-1:0] quot;
  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;

  logic signed [33:0] sq_x_full, sq_y_full;
  logic [27:0]        scaled;
  logic [2:0]         lo_stop, hi_stop, sel;
  logic [15:0]        thr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign cfg_ready = 1'b1;

  assign load_idx     = in_tdata[2:0];
  assign load_blob.px = in_tdata[18:3];
  assign load_blob.py = in_tdata[34:19];
  assign load_blob.vx = $signed(in_tdata[43:35]);
  assign load_blob.vy = $signed(in_tdata[52:44]);

  // ring: cell i takes from cell i+1, the last cell from the head
  assign mx = move_axis(cell_out[0].px, cell_out[0].vx, EDGE_HI_X);
  assign my = move_axis(cell_out[0].py, cell_out[0].vy, EDGE_HI_Y);
  always_comb begin
    moved.px = mx.pos;
    moved.vx = mx.vel;
    moved.py = my.pos;
    moved.vy = my.vel;
  end

  genvar gi;
  generate
    for (gi = 0; gi < BLOB_COUNT; gi++) begin : g_ring
      if (gi == BLOB_COUNT - 1) begin : g_tail
        assign cell_in[gi] = ring_move ? moved : cell_out[0];
      end else begin : g_body
        assign cell_in[gi] = cell_out[gi+1];
      end
      assign ctl[gi].load  = load_en && (load_idx == BLOB_IDX_W'(gi));
      assign ctl[gi].shift = ring_shift;
      mdps_blob_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[gi]),
        .load_data (load_blob),
        .from_next (cell_in[gi]),
        .blob      (cell_out[gi])
      );
    end
  endgenerate

  // d2 + 1.0, latched by the divider as it starts
  assign den = DEN_W'(sqx_r) + DEN_W'(sqy_r) + DEN_W'(65536);

  mdps_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .strength (strength_r),
    .den      (den),
    .done     (div_done),
    .quot     (quot)
  );

  mdps_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .field (acc_r),
    .done  (sqrt_done),
    .root  (root)
  );

  assign sq_x_full = dx_r * dx_r;
  assign sq_y_full = dy_r * dy_r;
  assign scaled    = root * gain_r;
  assign lo_stop   = t_r[18:16];
  assign hi_stop   = lo_stop + 3'd1;
  assign thr       = {BAYER[{py_r[1:0], px_r[1:0]}], 1'b1, 11'd0};
  assign sel       = (t_r[15:0] > thr) ? hi_stop : lo_stop;

  always_comb begin
    state_nxt     = state_r;
    blob_cnt_nxt  = blob_cnt_r;
    phase_nxt     = phase_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    acc_nxt       = acc_r;
    t_nxt         = t_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ring_shift    = 1'b0;
    ring_move     = 1'b0;
    load_en       = 1'b0;
    div_start     = 1'b0;
    sqrt_start    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        blob_cnt_nxt = '0;
        if (in_acc) begin
          case (cmd)
            CMD_LOAD: begin
              load_en = (load_idx < BLOB_IDX_W'(BLOB_COUNT));
            end
            CMD_TICK: begin
              if (in_tdata[53]) phase_nxt = phase_r + step_r;
              state_nxt = ST_TICK;
            end
            CMD_SHADE: begin
              px_nxt    = in_tdata[61:54];
              py_nxt    = in_tdata[69:62];
              acc_nxt   = '0;
              state_nxt = ST_DIST;
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        ring_shift = 1'b1;
        ring_move  = 1'b1;
        if (blob_cnt_r == BLOB_IDX_W'(BLOB_COUNT - 1)) begin
          blob_cnt_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          blob_cnt_nxt = blob_cnt_r + 1'b1;
        end
      end
      ST_DIST: begin
        dx_nxt    = $signed({1'b0, px_r, 8'd0}) - $signed({1'b0, cell_out[0].px});
        dy_nxt    = $signed({1'b0, py_r, 8'd0}) - $signed({1'b0, cell_out[0].py});
        state_nxt = ST_SQ;
      end
      ST_SQ: begin
        sqx_nxt   = sq_x_full[31:0];
        sqy_nxt   = sq_y_full[31:0];
        state_nxt = ST_DEN;
      end
      ST_DEN: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          acc_nxt    = acc_r + FIELD_W'(quot);
          ring_shift = 1'b1;
          if (blob_cnt_r == BLOB_IDX_W'(BLOB_COUNT - 1)) begin
            blob_cnt_nxt = '0;
            state_nxt    = ST_ROOT;
          end else begin
            blob_cnt_nxt = blob_cnt_r + 1'b1;
            state_nxt    = ST_DIST;
          end
        end
      end
      ST_ROOT: begin
        sqrt_start = 1'b1;
        state_nxt  = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sqrt_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        t_nxt     = scaled[18:0] + {phase_r, 3'b000};
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {py_r, px_r, palette_r[{sel, 3'b000} +: 8]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blob_cnt_r  <= '0;
      phase_r     <= '0;
      out_valid_r <= 1'b0;
      palette_r   <= '0;
      strength_r  <= 16'd3600;
      gain_r      <= 10'd141;
      step_r      <= 16'd328;
    end else begin
      state_r     <= state_nxt;
      blob_cnt_r  <= blob_cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PALETTE:  palette_r  <= cfg_data;
          CFG_STRENGTH: strength_r <= cfg_data[15:0];
          CFG_GAIN:     gain_r     <= cfg_data[9:0];
          CFG_PHASE:    step_r     <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    acc_r      <= acc_nxt;
    t_r        <= t_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `MDPS_ASSERT_IMPLY(a_out_from_seq, $rose(out_valid_r), $past(state_r == ST_OUT))
  `MDPS_ASSERT_IMPLY(a_div_done_state, div_done, state_r == ST_DIV)
  `MDPS_ASSERT_IMPLY(a_idle_ring_home, state_r == ST_IDLE, blob_cnt_r == '0)
  `MDPS_ASSERT_NEXT(a_root_follows, state_r == ST_ROOT, state_r == ST_ROOT_WAIT)

endmodule

// File: tb/tb.sv
// Testbench for metaball_dither_pixel_shader_core: directed and random command streams.
// Predicts every shaded pixel in-line and checks it; depends on mdps_pkg and the RTL.
`default_nettype none
module tb import mdps_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE = 2'd3;  // undefined command, dropped by the block
  localparam int DRAIN_CYCLES = 220;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] x;
    logic [7:0] colour;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  metaball_dither_pixel_shader_core dut (.*);

  // shader model state
  logic [63:0]       stops;
  logic [15:0]       strength;
  logic [9:0]        gain;
  logic [15:0]       step;
  logic [15:0]       phase;
  logic [15:0]       pos_x [BLOB_COUNT];
  logic [15:0]       pos_y [BLOB_COUNT];
  logic signed [8:0] vel_x [BLOB_COUNT];
  logic signed [8:0] vel_y [BLOB_COUNT];

  const logic [3:0] dither [16] = '{0, 8, 2, 10, 12, 4, 14, 6, 3, 11, 1, 9, 15, 7, 13, 5};

  pixel_t pixel_q[$];
  int     errors;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic move_blob_axis(inout logic [15:0] p, inout logic signed [8:0] v,
                                input int span);
    int lo, hi, np;
    lo = EDGE_MARGIN * 256;
    hi = (span - EDGE_MARGIN) * 256;
    if (hi > 65535) hi = 65535;
    np = int'(p) + int'(v);
    if (np < lo || np > hi) v = (v == -9'sd256) ? 9'sd255 : -v;
    if (np < lo) np = lo;
    if (np > hi) np = hi;
    p = np[15:0];
  endtask

  function automatic logic [7:0] shade_colour(logic [7:0] px, logic [7:0] py);
    longint signed   dx, dy;
    longint unsigned field, d2, s, t, frac, thr;
    logic [2:0]      lo, hi, sel;
    field = 0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      dx = longint'(px) * 256 - longint'(pos_x[i]);
      dy = longint'(py) * 256 - longint'(pos_y[i]);
      d2 = dx * dx + dy * dy;
      field += (longint'(strength) << 24) / (d2 + 65536);
    end
    s = int_root(field << 8);
    t = (s * gain + (longint'(phase) << 3)) & 64'h7FFFF;
    lo = t[18:16];
    hi = lo + 3'd1;
    frac = t & 64'hFFFF;
    thr = (longint'(dither[{py[1:0], px[1:0]}]) * 2 + 1) * 2048;
    sel = (frac > thr) ? hi : lo;
    return stops[sel*8 +: 8];
  endfunction

  // Update model on an accepted item; queue the expected pixel for shades.
  task automatic model_item(logic [1:0] cmd, logic [71:0] d);
    pixel_t e;
    if (cmd == CMD_LOAD) begin
      if (d[2:0] < BLOB_COUNT) begin
        pos_x[d[2:0]] = d[18:3];
        pos_y[d[2:0]] = d[34:19];
        vel_x[d[2:0]] = d[43:35];
        vel_y[d[2:0]] = d[52:44];
      end
    end else if (cmd == CMD_TICK) begin
      if (d[53]) phase = phase + step;
      for (int i = 0; i < BLOB_COUNT; i++) begin
        move_blob_axis(pos_x[i], vel_x[i], SCREEN_WIDTH);
        move_blob_axis(pos_y[i], vel_y[i], SCREEN_HEIGHT);
      end
    end else if (cmd == CMD_SHADE) begin
      e.x = d[61:54];
      e.y = d[69:62];
      e.colour = shade_colour(e.x, e.y);
      pixel_q.push_back(e);
    end
  endtask

  task automatic send_item(logic [1:0] cmd, logic [2:0] idx, logic [15:0] bx, logic [15:0] by,
                           logic [8:0] vx, logic [8:0] vy, logic drift,
                           logic [7:0] px, logic [7:0] py);
    logic [71:0] d;
    d = {2'b00, py, px, drift, vy, vx, by, bx, idx};
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      in_tdata  <= 72'($urandom);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model_item(cmd, d);
  endtask

  task automatic shade(logic [7:0] px, logic [7:0] py);
    send_item(CMD_SHADE, 3'($urandom), 16'($urandom), 16'($urandom), 9'($urandom),
              9'($urandom), 1'($urandom), px, py);
  endtask

  task automatic load_blob(logic [2:0] idx, logic [15:0] bx, logic [15:0] by,
                           logic [8:0] vx, logic [8:0] vy);
    send_item(CMD_LOAD, idx, bx, by, vx, vy, 1'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic tick(logic drift);
    send_item(CMD_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 9'($urandom),
              9'($urandom), drift, 8'($urandom), 8'($urandom));
  endtask

  // Drain, then let a trailing tick or load finish before touching a register.
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PALETTE:  stops = val;
      CFG_STRENGTH: strength = val[15:0];
      CFG_GAIN:     gain = val[9:0];
      CFG_PHASE:    step = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result checker
  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %h", $realtime, out_tdata);
        errors++;
      end else begin
        e = pixel_q.pop_front();
        if (out_tdata[7:0] !== e.colour)
          begin $display("%0t: colour_index expected %h actual %h", $realtime, e.colour,
                         out_tdata[7:0]); errors++; end
        if (out_tdata[15:8] !== e.x)
          begin $display("%0t: out_x expected %h actual %h", $realtime, e.x,
                         out_tdata[15:8]); errors++; end
        if (out_tdata[23:16] !== e.y)
          begin $display("%0t: out_y expected %h actual %h", $realtime, e.y,
                         out_tdata[23:16]); errors++; end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic test_directed();
    load_blob(0, 16'h0000, 16'h0000, 9'h100, 9'h100);  // most negative velocity
    load_blob(1, 16'hFFFF, 16'hFFFF, 9'h0FF, 9'h0FF);
    load_blob(2, 16'h8000, 16'h4000, 9'h101, 9'h001);
    load_blob(3, 16'h0500, 16'hFB00, 9'h000, 9'h1FF);
    load_blob(4, 16'h3210, 16'hC0DE, 9'h055, 9'h1AA);
    load_blob(5, 16'h1111, 16'h2222, 9'h033, 9'h044);  // out-of-range index, dropped
    load_blob(7, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF);
    send_item(CMD_NONE, 3'd0, 16'hFFFF, 16'hFFFF, 9'h1FF, 9'h1FF, 1'b1, 8'hFF, 8'hFF);
    shade(8'h00, 8'h00);
    shade(8'hFF, 8'hFF);
    shade(8'h80, 8'h40);
    shade(8'h00, 8'hFF);  // off-margin pixels are shaded the same way
    tick(1'b1);
    tick(1'b0);
    shade(8'h05, 8'h05);
    shade(8'h03, 8'h02);
    for (int i = 0; i < 4; i++) tick(1'b1);
    for (int i = 0; i < 4; i++) shade(8'(i * 5), 8'(i * 7 + 1));
  endtask

  task automatic random_items(int n);
    int k, r;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 60) begin
        shade(8'($urandom), 8'($urandom));
        k++;
      end else if (r < 75) begin
        tick(1'($urandom));
        k++;
      end else if (r < 93) begin
        load_blob(3'($urandom_range(BLOB_COUNT - 1)), 16'($urandom), 16'($urandom),
                  9'($urandom), 9'($urandom));
        k++;
      end else if (r < 97) begin
        load_blob(3'($urandom_range(7, BLOB_COUNT)), 16'($urandom), 16'($urandom),
                  9'($urandom), 9'($urandom));
      end else begin
        send_item(CMD_NONE, 3'($urandom), 16'($urandom), 16'($urandom), 9'($urandom),
                  9'($urandom), 1'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_PALETTE, {$urandom, $urandom});
    write_reg(CFG_STRENGTH, 64'd65535);
    write_reg(CFG_GAIN, 64'd1023);
    write_reg(CFG_PHASE, 64'd65535);
    random_items(300);
    write_reg(CFG_STRENGTH, 64'd1);
    write_reg(CFG_GAIN, 64'd0);
    write_reg(CFG_PHASE, 64'd0);
    write_reg(CFG_PALETTE, 64'hFFFF_FFFF_FFFF_FFFF);
    random_items(150);
    write_reg(CFG_PALETTE, 64'h0706_0504_0302_0100);
    write_reg(CFG_STRENGTH, 64'($urandom_range(65535, 1)));
    write_reg(CFG_GAIN, 64'($urandom_range(1023)));
    write_reg(CFG_PHASE, 64'($urandom_range(65535)));
  endtask

  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 600;
    random_items(60);
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;   recv_stall_pct = 0;  random_items(300);
    send_idle_pct = 48;  recv_stall_pct = 0;  random_items(300);
    send_idle_pct = 0;   recv_stall_pct = 48; random_items(300);
    send_idle_pct = 16;  recv_stall_pct = 16; random_items(300);
    send_idle_pct = 0;   recv_stall_pct = 0;
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PALETTE;
    cfg_data = '0;
    stops = '0;
    strength = 16'd3600;
    gain = 10'd141;
    step = 16'd328;
    phase = '0;
    for (int i = 0; i < BLOB_COUNT; i++) begin
      pos_x[i] = '0; pos_y[i] = '0; vel_x[i] = '0; vel_y[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_reg(CFG_PALETTE, 64'hF0E1_D2C3_B4A5_9687);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_idle_phases();
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pixel_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire
